/* rtl/stok_pkg.sv */
// Shared types, codes and character helpers for the script tokenizer.
`default_nettype none

package stok_pkg;

    localparam int LINE_WIDTH   = 20;
    localparam int COLUMN_WIDTH = 16;
    localparam int VALUE_WIDTH  = 64;
    localparam int MAX_RECS     = 3;

    typedef logic [1:0] t_rtype;
    typedef logic [4:0] t_kind;

    localparam t_rtype REC_TEXT  = 2'd0;
    localparam t_rtype REC_TOKEN = 2'd1;
    localparam t_rtype REC_ERROR = 2'd2;

    localparam t_kind KIND_END     = 5'd0;
    localparam t_kind KIND_IDENT   = 5'd1;
    localparam t_kind KIND_NUMBER  = 5'd2;
    localparam t_kind KIND_STRING  = 5'd3;
    localparam t_kind KIND_COLON   = 5'd4;
    localparam t_kind KIND_COMMA   = 5'd5;
    localparam t_kind KIND_SEMI    = 5'd6;
    localparam t_kind KIND_DOT     = 5'd7;
    localparam t_kind KIND_LBRACE  = 5'd8;
    localparam t_kind KIND_RBRACE  = 5'd9;
    localparam t_kind KIND_LPAREN  = 5'd10;
    localparam t_kind KIND_RPAREN  = 5'd11;
    localparam t_kind KIND_LBRACK  = 5'd12;
    localparam t_kind KIND_RBRACK  = 5'd13;
    localparam t_kind KIND_PLUS_EQ = 5'd14;
    localparam t_kind KIND_ARROW   = 5'd15;
    localparam t_kind KIND_MINUS_EQ = 5'd16;
    localparam t_kind KIND_EQ_EQ   = 5'd17;
    localparam t_kind KIND_ASSIGN  = 5'd18;
    localparam t_kind KIND_NOT_EQ  = 5'd19;
    localparam t_kind KIND_GE      = 5'd20;
    localparam t_kind KIND_GT      = 5'd21;
    localparam t_kind KIND_LE      = 5'd22;
    localparam t_kind KIND_LT      = 5'd23;

    localparam logic ERR_UNEXPECTED = 1'b0;
    localparam logic ERR_UNTERM_STR = 1'b1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef struct packed {
        t_rtype                  rtype;
        t_kind                   kind;
        logic [LINE_WIDTH-1:0]   line;
        logic [COLUMN_WIDTH-1:0] col;
        logic [VALUE_WIDTH-1:0]  value;
        logic [7:0]              tbyte;
        logic                    err;
        logic                    last;
    } t_rec;

    // records caused by one beat, first record in slot 0
    typedef struct packed {
        logic [1:0]               cnt;
        t_rec [MAX_RECS-1:0]      rec;
    } t_recs;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic t_kind single_kind(logic [7:0] c);
        t_kind k;
        case (c)
            CH_COLON:  k = KIND_COLON;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            CH_DOT:    k = KIND_DOT;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            default:   k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic t_kind pair_kind(logic [7:0] c, logic eq);
        t_kind k;
        case (c)
            CH_PLUS: k = eq ? KIND_PLUS_EQ : KIND_END;
            CH_EQ:   k = eq ? KIND_EQ_EQ : KIND_ASSIGN;
            CH_BANG: k = eq ? KIND_NOT_EQ : KIND_END;
            CH_GT:   k = eq ? KIND_GE : KIND_GT;
            default: k = eq ? KIND_LE : KIND_LT;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] esc_byte(logic [7:0] c);
        logic [7:0] b;
        case (c)
            CH_LOW_N: b = CH_NL;
            CH_LOW_T: b = CH_TAB;
            CH_LOW_R: b = CH_CR;
            default:  b = c;
        endcase
        return b;
    endfunction

    function automatic t_rec mk_rec(t_rtype rtype, t_kind kind,
                                    logic [LINE_WIDTH-1:0] line,
                                    logic [COLUMN_WIDTH-1:0] col,
                                    logic [VALUE_WIDTH-1:0] value,
                                    logic [7:0] tbyte, logic err);
        t_rec r;
        r.rtype = rtype;
        r.kind  = kind;
        r.line  = line;
        r.col   = col;
        r.value = value;
        r.tbyte = tbyte;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic t_recs push(t_recs rs, t_rec r);
        t_recs o;
        o = rs;
        o.rec[o.cnt] = r;
        o.cnt = o.cnt + 2'd1;
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/script_tokenizer.sv */
// Streaming tokenizer: byte input channel, record output channel.
//
// Input channel (i_valid/o_ready): one source byte per beat, or an end-of-text
// marker when i_end_of_text is set. Output channel (o_valid/i_ready): one
// record per beat - a text byte, a completed token or an error; o_last marks
// the final record caused by an input beat.
// Each accepted byte is lexed in the cycle it is taken; its records (0 to 2)
// are loaded into a three-slot record buffer and the first one is presented
// on the next cycle. Throughput: one byte per cycle while each byte causes
// at most one record and the receiver is ready. A byte causing more records
// holds the input until the buffer's last record leaves, since the next byte
// is taken only as the buffer's last record leaves.
// Receiver stall: records wait in the buffer, and o_ready drops until the
// buffer is empty or its last record is being taken.
// Reset: buffer empty, lexer idle at line 1, column 1. After an end token or
// an error, bytes are swallowed until the end-of-text beat, which also puts
// the lexer back to its reset state for the next text.
`default_nettype none

module script_tokenizer
    import stok_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [7:0]                i_ch,
    input  wire logic                      i_end_of_text,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [1:0]                     o_record_type,
    output logic [4:0]                     o_token_kind,
    output logic [LINE_WIDTH-1:0]          o_token_line,
    output logic [COLUMN_WIDTH-1:0]        o_token_column,
    output logic signed [VALUE_WIDTH-1:0]  o_number_value,
    output logic [7:0]                     o_text_byte,
    output logic                           o_error_code,
    output logic                           o_last
);

    t_recs               w_recs;
    t_rec [MAX_RECS-1:0] r_buf;
    logic [1:0]          r_cnt;
    logic                w_in_acc;
    logic                w_out_acc;

    assign o_valid   = r_cnt != 2'd0;
    assign w_out_acc = o_valid && i_ready;
    assign o_ready   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign w_in_acc  = i_valid && o_ready;

    stok_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_in_acc),
        .i_ch    (i_ch),
        .i_eot   (i_end_of_text),
        .o_recs  (w_recs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_in_acc) begin
            r_cnt <= w_recs.cnt;
        end else if (w_out_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // payload slots: load a fresh set, or shift toward slot 0 on each beat out
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_buf <= w_recs.rec;
        end else if (w_out_acc) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    assign o_record_type  = r_buf[0].rtype;
    assign o_token_kind   = r_buf[0].kind;
    assign o_token_line   = r_buf[0].line;
    assign o_token_column = r_buf[0].col;
    assign o_number_value = signed'(r_buf[0].value);
    assign o_text_byte    = r_buf[0].tbyte;
    assign o_error_code   = r_buf[0].err;
    assign o_last         = r_buf[0].last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_out_acc)))
        else $error("input taken while undelivered records remain");

    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("record group ended without a last record");

    a_records_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_recs.cnt != 2'd0 |=> o_valid && r_cnt == $past(w_recs.cnt))
        else $error("records of an accepted byte not presented");

    a_value_only_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_type != REC_TOKEN |-> o_number_value == '0)
        else $error("number value on a non-token record");

endmodule

`default_nettype wire

/* rtl/stok_lexer.sv */
// Lexer state registers and the per-byte next-state and record logic.
`default_nettype none

module stok_lexer
    import stok_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_eot,
    output t_recs           o_recs
);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_IDENT, M_MINUS,
        M_INT, M_FRAC, M_STR, M_ESC, M_PAIR, M_DONE
    } t_mode;

    localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
    localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);

    t_mode                   r_mode, n_mode;
    logic [7:0]              r_held, n_held;
    logic [LINE_WIDTH-1:0]   r_line, n_line;
    logic [COLUMN_WIDTH-1:0] r_col, n_col;
    logic [LINE_WIDTH-1:0]   r_sl, n_sl;
    logic [COLUMN_WIDTH-1:0] r_sc, n_sc;
    logic [VALUE_WIDTH-1:0]  r_acc, n_acc;
    logic                    r_neg, n_neg;

    logic [VALUE_WIDTH-1:0]  w_numval;
    logic [VALUE_WIDTH-1:0]  w_acc10;
    logic [VALUE_WIDTH-1:0]  w_digit;

    assign w_numval = r_neg ? (VALUE_WIDTH'(0) - r_acc) : r_acc;
    assign w_digit  = {{(VALUE_WIDTH-4){1'b0}}, i_ch[3:0]};
    assign w_acc10  = (r_acc << 3) + (r_acc << 1) + w_digit;

    always_comb begin
        t_recs rs;
        logic  inc;
        logic  nl;
        logic  run_idle;
        t_kind k;
        rs       = '0;
        inc      = 1'b0;
        nl       = 1'b0;
        run_idle = 1'b0;
        k        = KIND_END;
        n_mode   = r_mode;
        n_held   = r_held;
        n_line   = r_line;
        n_col    = r_col;
        n_sl     = r_sl;
        n_sc     = r_sc;
        n_acc    = r_acc;
        n_neg    = r_neg;

        if (i_eot) begin
            case (r_mode)
                M_IDLE, M_LINE, M_BLOCK, M_STAR: begin
                    rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_line, r_col, '0, '0, 1'b0));
                end
                M_SLASH: begin
                    rs = push(rs, mk_rec(REC_ERROR, KIND_END, r_sl, r_sc, '0, '0,
                                         ERR_UNEXPECTED));
                end
                M_IDENT: begin
                    rs = push(rs, mk_rec(REC_TOKEN, KIND_IDENT, r_sl, r_sc, '0, '0, 1'b0));
                    rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_line, r_col, '0, '0, 1'b0));
                end
                M_MINUS: begin
                    rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_sl, r_sc, '0, '0, 1'b0));
                end
                M_INT, M_FRAC: begin
                    rs = push(rs, mk_rec(REC_TOKEN, KIND_NUMBER, r_sl, r_sc, w_numval, '0,
                                         1'b0));
                    rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_line, r_col, '0, '0, 1'b0));
                end
                M_STR: begin
                    rs = push(rs, mk_rec(REC_ERROR, KIND_END, r_line, r_col, '0, '0,
                                         ERR_UNTERM_STR));
                end
                M_ESC: begin
                    // dangling backslash goes out as text before the error
                    rs = push(rs, mk_rec(REC_TEXT, KIND_STRING, r_sl, r_sc, '0, CH_BSLASH,
                                         1'b0));
                    rs = push(rs, mk_rec(REC_ERROR, KIND_END, r_line, r_col, '0, '0,
                                         ERR_UNTERM_STR));
                end
                M_PAIR: begin
                    if (r_held == CH_PLUS || r_held == CH_BANG) begin
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_sl, r_sc, '0, '0, 1'b0));
                    end else begin
                        rs = push(rs, mk_rec(REC_TOKEN, pair_kind(r_held, 1'b0), r_sl, r_sc,
                                             '0, '0, 1'b0));
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_line, r_col, '0, '0,
                                             1'b0));
                    end
                end
                default: begin
                end
            endcase
            n_mode = M_IDLE;
            n_held = '0;
            n_line = LINE_ONE;
            n_col  = COL_ONE;
            n_sl   = LINE_ONE;
            n_sc   = COL_ONE;
            n_acc  = '0;
            n_neg  = 1'b0;
        end else begin
            case (r_mode)
                M_IDLE: run_idle = 1'b1;
                M_SLASH: begin
                    if (i_ch == CH_SLASH) begin
                        inc = 1'b1;
                        n_mode = M_LINE;
                    end else if (i_ch == CH_STAR) begin
                        inc = 1'b1;
                        n_mode = M_BLOCK;
                    end else begin
                        rs = push(rs, mk_rec(REC_ERROR, KIND_END, r_sl, r_sc, '0, '0,
                                             ERR_UNEXPECTED));
                        n_mode = M_DONE;
                    end
                end
                M_LINE: begin
                    if (i_ch == CH_NL) begin
                        nl = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        inc = 1'b1;
                    end
                end
                M_BLOCK, M_STAR: begin
                    if (r_mode == M_STAR && i_ch == CH_SLASH) begin
                        inc = 1'b1;
                        n_mode = M_IDLE;
                    end else if (i_ch == CH_STAR) begin
                        inc = 1'b1;
                        n_mode = M_STAR;
                    end else if (i_ch == CH_NL) begin
                        nl = 1'b1;
                        n_mode = M_BLOCK;
                    end else begin
                        inc = 1'b1;
                        n_mode = M_BLOCK;
                    end
                end
                M_IDENT: begin
                    if (is_word(i_ch)) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TEXT, KIND_IDENT, r_sl, r_sc, '0, i_ch, 1'b0));
                    end else begin
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_IDENT, r_sl, r_sc, '0, '0, 1'b0));
                        run_idle = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (is_digit(i_ch)) begin
                        inc = 1'b1;
                        n_neg = 1'b1;
                        n_acc = w_digit;
                        rs = push(rs, mk_rec(REC_TEXT, KIND_NUMBER, r_sl, r_sc, '0, CH_MINUS,
                                             1'b0));
                        rs = push(rs, mk_rec(REC_TEXT, KIND_NUMBER, r_sl, r_sc, '0, i_ch, 1'b0));
                        n_mode = M_INT;
                    end else if (i_ch == CH_GT) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_ARROW, r_sl, r_sc, '0, '0, 1'b0));
                        n_mode = M_IDLE;
                    end else if (i_ch == CH_EQ) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_MINUS_EQ, r_sl, r_sc, '0, '0,
                                             1'b0));
                        n_mode = M_IDLE;
                    end else begin
                        // lone minus closes the text
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_sl, r_sc, '0, '0, 1'b0));
                        n_mode = M_DONE;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit(i_ch) || i_ch == CH_DOT) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TEXT, KIND_NUMBER, r_sl, r_sc, '0, i_ch, 1'b0));
                        if (r_mode == M_INT) begin
                            if (i_ch == CH_DOT) begin
                                n_mode = M_FRAC;
                            end else begin
                                n_acc = w_acc10;
                            end
                        end
                    end else begin
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_NUMBER, r_sl, r_sc, w_numval, '0,
                                             1'b0));
                        run_idle = 1'b1;
                    end
                end
                M_STR: begin
                    inc = 1'b1;
                    if (i_ch == CH_QUOTE) begin
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_STRING, r_sl, r_sc, '0, '0, 1'b0));
                        n_mode = M_IDLE;
                    end else if (i_ch == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        rs = push(rs, mk_rec(REC_TEXT, KIND_STRING, r_sl, r_sc, '0, i_ch, 1'b0));
                    end
                end
                M_ESC: begin
                    inc = 1'b1;
                    rs = push(rs, mk_rec(REC_TEXT, KIND_STRING, r_sl, r_sc, '0,
                                         esc_byte(i_ch), 1'b0));
                    n_mode = M_STR;
                end
                M_PAIR: begin
                    if (i_ch == CH_EQ) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TOKEN, pair_kind(r_held, 1'b1), r_sl, r_sc,
                                             '0, '0, 1'b0));
                        n_mode = M_IDLE;
                    end else if (r_held == CH_PLUS || r_held == CH_BANG) begin
                        rs = push(rs, mk_rec(REC_TOKEN, KIND_END, r_sl, r_sc, '0, '0, 1'b0));
                        n_mode = M_DONE;
                    end else begin
                        rs = push(rs, mk_rec(REC_TOKEN, pair_kind(r_held, 1'b0), r_sl, r_sc,
                                             '0, '0, 1'b0));
                        run_idle = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // between-token handling; start position is the current position
            if (run_idle) begin
                n_mode = M_IDLE;
                if (i_ch == CH_SPACE || i_ch == CH_TAB || i_ch == CH_CR) begin
                    inc = 1'b1;
                end else if (i_ch == CH_NL) begin
                    nl = 1'b1;
                end else begin
                    n_sl = r_line;
                    n_sc = r_col;
                    k    = single_kind(i_ch);
                    if (i_ch == CH_SLASH) begin
                        inc = 1'b1;
                        n_mode = M_SLASH;
                    end else if (is_alpha(i_ch) || i_ch == CH_UNDER) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TEXT, KIND_IDENT, r_line, r_col, '0, i_ch,
                                             1'b0));
                        n_mode = M_IDENT;
                    end else if (is_digit(i_ch)) begin
                        inc = 1'b1;
                        n_acc = w_digit;
                        n_neg = 1'b0;
                        rs = push(rs, mk_rec(REC_TEXT, KIND_NUMBER, r_line, r_col, '0, i_ch,
                                             1'b0));
                        n_mode = M_INT;
                    end else if (i_ch == CH_MINUS) begin
                        inc = 1'b1;
                        n_mode = M_MINUS;
                    end else if (i_ch == CH_QUOTE) begin
                        inc = 1'b1;
                        n_mode = M_STR;
                    end else if (i_ch == CH_PLUS || i_ch == CH_EQ || i_ch == CH_BANG ||
                                 i_ch == CH_GT || i_ch == CH_LT) begin
                        inc = 1'b1;
                        n_held = i_ch;
                        n_mode = M_PAIR;
                    end else if (k != KIND_END) begin
                        inc = 1'b1;
                        rs = push(rs, mk_rec(REC_TOKEN, k, r_line, r_col, '0, '0, 1'b0));
                    end else begin
                        rs = push(rs, mk_rec(REC_ERROR, KIND_END, r_line, r_col, '0, '0,
                                             ERR_UNEXPECTED));
                        n_mode = M_DONE;
                    end
                end
            end

            // position counters saturate
            if (nl) begin
                if (r_line != '1) begin
                    n_line = r_line + LINE_ONE;
                end
                n_col = COL_ONE;
            end else if (inc && r_col != '1) begin
                n_col = r_col + COL_ONE;
            end
        end

        if (rs.cnt != 2'd0) begin
            rs.rec[rs.cnt - 2'd1].last = 1'b1;
        end
        o_recs = rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_held <= '0;
            r_line <= LINE_ONE;
            r_col  <= COL_ONE;
            r_sl   <= LINE_ONE;
            r_sc   <= COL_ONE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_line <= n_line;
            r_col  <= n_col;
            r_sl   <= n_sl;
            r_sc   <= n_sc;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
        end
    end

endmodule

`default_nettype wire

/* test/tok_checker.sv */
// Checker for the script tokenizer: predicts the records of every input beat and compares.
module tok_checker
    import stok_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  wire logic [7:0]              i_ch,
    input  wire logic                    i_end_of_text,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic [1:0]              i_record_type,
    input  wire logic [4:0]              i_token_kind,
    input  wire logic [LINE_WIDTH-1:0]   i_token_line,
    input  wire logic [COLUMN_WIDTH-1:0] i_token_column,
    input  wire logic [VALUE_WIDTH-1:0]  i_number_value,
    input  wire logic [7:0]              i_text_byte,
    input  wire logic                    i_error_code,
    input  wire logic                    i_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        LX_IDLE, LX_SLASH, LX_LINE_CMT, LX_BLOCK_CMT, LX_BLOCK_STAR, LX_IDENT, LX_MINUS,
        LX_INT, LX_FRAC, LX_STR, LX_ESC, LX_PAIR, LX_DONE
    } t_lex;

    t_lex                    lx_mode;
    logic [7:0]              op_byte;
    logic [LINE_WIDTH-1:0]   cur_line;
    logic [LINE_WIDTH-1:0]   tok_line;
    logic [COLUMN_WIDTH-1:0] cur_col;
    logic [COLUMN_WIDTH-1:0] tok_col;
    logic [VALUE_WIDTH-1:0]  num_acc;
    logic                    num_neg;

    t_rec beat_recs[$];
    t_rec want_recs[$];

    function automatic logic letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_char(logic [7:0] c);
        return letter(c) || digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] digit_val(logic [7:0] c);
        return {{(VALUE_WIDTH-4){1'b0}}, c[3:0]};
    endfunction

    function automatic t_kind punct_kind(logic [7:0] c);
        case (c)
            CH_COLON:  return KIND_COLON;
            CH_COMMA:  return KIND_COMMA;
            CH_SEMI:   return KIND_SEMI;
            CH_DOT:    return KIND_DOT;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_LBRACK: return KIND_LBRACK;
            CH_RBRACK: return KIND_RBRACK;
            default:   return KIND_END;
        endcase
    endfunction

    // kind of an operator that may take a trailing '='
    function automatic t_kind op_kind(logic [7:0] c, logic with_eq);
        case (c)
            CH_PLUS: return with_eq ? KIND_PLUS_EQ : KIND_END;
            CH_EQ:   return with_eq ? KIND_EQ_EQ : KIND_ASSIGN;
            CH_BANG: return with_eq ? KIND_NOT_EQ : KIND_END;
            CH_GT:   return with_eq ? KIND_GE : KIND_GT;
            default: return with_eq ? KIND_LE : KIND_LT;
        endcase
    endfunction

    function automatic logic lone_op(logic [7:0] c);
        return c == CH_PLUS || c == CH_BANG;
    endfunction

    task automatic lex_reset();
        lx_mode  = LX_IDLE;
        op_byte  = 8'h00;
        cur_line = LINE_WIDTH'(1);
        cur_col  = COLUMN_WIDTH'(1);
        tok_line = LINE_WIDTH'(1);
        tok_col  = COLUMN_WIDTH'(1);
        num_acc  = '0;
        num_neg  = 1'b0;
    endtask

    task automatic bump_col();
        if (cur_col != '1)
            cur_col = cur_col + COLUMN_WIDTH'(1);
    endtask

    task automatic next_line();
        if (cur_line != '1)
            cur_line = cur_line + LINE_WIDTH'(1);
        cur_col = COLUMN_WIDTH'(1);
    endtask

    task automatic add_rec(t_rtype rt, t_kind k, logic [LINE_WIDTH-1:0] ln,
                           logic [COLUMN_WIDTH-1:0] cl, logic [VALUE_WIDTH-1:0] v,
                           logic [7:0] b, logic e);
        t_rec r;
        r.rtype = rt;
        r.kind  = k;
        r.line  = ln;
        r.col   = cl;
        r.value = v;
        r.tbyte = b;
        r.err   = e;
        r.last  = 1'b0;
        beat_recs.insert(beat_recs.size(), r);
    endtask

    task automatic add_text(t_kind k, logic [7:0] b);
        add_rec(REC_TEXT, k, tok_line, tok_col, '0, b, 1'b0);
    endtask

    task automatic add_token(t_kind k);
        add_rec(REC_TOKEN, k, tok_line, tok_col, '0, 8'h00, 1'b0);
    endtask

    task automatic add_end_here();
        add_rec(REC_TOKEN, KIND_END, cur_line, cur_col, '0, 8'h00, 1'b0);
    endtask

    task automatic add_number();
        add_rec(REC_TOKEN, KIND_NUMBER, tok_line, tok_col, num_neg ? -num_acc : num_acc,
                8'h00, 1'b0);
    endtask

    task automatic add_error(logic [LINE_WIDTH-1:0] ln, logic [COLUMN_WIDTH-1:0] cl, logic e);
        add_rec(REC_ERROR, KIND_END, ln, cl, '0, 8'h00, e);
    endtask

    task automatic lex_idle(logic [7:0] c);
        t_kind k;
        k = punct_kind(c);
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            bump_col();
        end else if (c == CH_NL) begin
            next_line();
        end else begin
            tok_line = cur_line;
            tok_col  = cur_col;
            if (c == CH_SLASH) begin
                bump_col();
                lx_mode = LX_SLASH;
            end else if (letter(c) || c == CH_UNDER) begin
                bump_col();
                add_text(KIND_IDENT, c);
                lx_mode = LX_IDENT;
            end else if (digit(c)) begin
                bump_col();
                num_acc = digit_val(c);
                num_neg = 1'b0;
                add_text(KIND_NUMBER, c);
                lx_mode = LX_INT;
            end else if (c == CH_MINUS) begin
                bump_col();
                lx_mode = LX_MINUS;
            end else if (c == CH_QUOTE) begin
                bump_col();
                lx_mode = LX_STR;
            end else if (c == CH_PLUS || c == CH_EQ || c == CH_BANG || c == CH_GT
                         || c == CH_LT) begin
                bump_col();
                op_byte = c;
                lx_mode = LX_PAIR;
            end else if (k != KIND_END) begin
                bump_col();
                add_token(k);
            end else begin
                add_error(tok_line, tok_col, ERR_UNEXPECTED);
                lx_mode = LX_DONE;
            end
        end
    endtask

    task automatic lex_byte(logic [7:0] c);
        case (lx_mode)
            LX_IDLE: lex_idle(c);
            LX_SLASH: begin
                if (c == CH_SLASH) begin
                    bump_col();
                    lx_mode = LX_LINE_CMT;
                end else if (c == CH_STAR) begin
                    bump_col();
                    lx_mode = LX_BLOCK_CMT;
                end else begin
                    add_error(tok_line, tok_col, ERR_UNEXPECTED);
                    lx_mode = LX_DONE;
                end
            end
            LX_LINE_CMT: begin
                if (c == CH_NL) begin
                    next_line();
                    lx_mode = LX_IDLE;
                end else begin
                    bump_col();
                end
            end
            LX_BLOCK_CMT, LX_BLOCK_STAR: begin
                if (lx_mode == LX_BLOCK_STAR && c == CH_SLASH) begin
                    bump_col();
                    lx_mode = LX_IDLE;
                end else if (c == CH_STAR) begin
                    bump_col();
                    lx_mode = LX_BLOCK_STAR;
                end else if (c == CH_NL) begin
                    next_line();
                    lx_mode = LX_BLOCK_CMT;
                end else begin
                    bump_col();
                    lx_mode = LX_BLOCK_CMT;
                end
            end
            LX_IDENT: begin
                if (word_char(c)) begin
                    bump_col();
                    add_text(KIND_IDENT, c);
                end else begin
                    add_token(KIND_IDENT);
                    lx_mode = LX_IDLE;
                    lex_idle(c);
                end
            end
            LX_MINUS: begin
                if (digit(c)) begin
                    bump_col();
                    num_neg = 1'b1;
                    num_acc = digit_val(c);
                    add_text(KIND_NUMBER, CH_MINUS);
                    add_text(KIND_NUMBER, c);
                    lx_mode = LX_INT;
                end else if (c == CH_GT) begin
                    bump_col();
                    add_token(KIND_ARROW);
                    lx_mode = LX_IDLE;
                end else if (c == CH_EQ) begin
                    bump_col();
                    add_token(KIND_MINUS_EQ);
                    lx_mode = LX_IDLE;
                end else begin
                    add_token(KIND_END);
                    lx_mode = LX_DONE;
                end
            end
            LX_INT, LX_FRAC: begin
                if (digit(c) || c == CH_DOT) begin
                    bump_col();
                    add_text(KIND_NUMBER, c);
                    if (lx_mode == LX_INT) begin
                        if (c == CH_DOT)
                            lx_mode = LX_FRAC;
                        else
                            num_acc = num_acc * VALUE_WIDTH'(10) + digit_val(c);
                    end
                end else begin
                    add_number();
                    lx_mode = LX_IDLE;
                    lex_idle(c);
                end
            end
            LX_STR: begin
                bump_col();
                if (c == CH_QUOTE) begin
                    add_token(KIND_STRING);
                    lx_mode = LX_IDLE;
                end else if (c == CH_BSLASH) begin
                    lx_mode = LX_ESC;
                end else begin
                    add_text(KIND_STRING, c);
                end
            end
            LX_ESC: begin
                bump_col();
                case (c)
                    CH_LOW_N: add_text(KIND_STRING, CH_NL);
                    CH_LOW_T: add_text(KIND_STRING, CH_TAB);
                    CH_LOW_R: add_text(KIND_STRING, CH_CR);
                    default:  add_text(KIND_STRING, c);
                endcase
                lx_mode = LX_STR;
            end
            LX_PAIR: begin
                if (c == CH_EQ) begin
                    bump_col();
                    add_token(op_kind(op_byte, 1'b1));
                    lx_mode = LX_IDLE;
                end else if (lone_op(op_byte)) begin
                    add_token(KIND_END);
                    lx_mode = LX_DONE;
                end else begin
                    add_token(op_kind(op_byte, 1'b0));
                    lx_mode = LX_IDLE;
                    lex_idle(c);
                end
            end
            default: ;
        endcase
    endtask

    task automatic lex_end();
        case (lx_mode)
            LX_IDLE, LX_LINE_CMT, LX_BLOCK_CMT, LX_BLOCK_STAR: add_end_here();
            LX_SLASH: add_error(tok_line, tok_col, ERR_UNEXPECTED);
            LX_IDENT: begin
                add_token(KIND_IDENT);
                add_end_here();
            end
            LX_MINUS: add_token(KIND_END);
            LX_INT, LX_FRAC: begin
                add_number();
                add_end_here();
            end
            LX_STR: add_error(cur_line, cur_col, ERR_UNTERM_STR);
            LX_ESC: begin
                add_text(KIND_STRING, CH_BSLASH);
                add_error(cur_line, cur_col, ERR_UNTERM_STR);
            end
            LX_PAIR: begin
                if (lone_op(op_byte)) begin
                    add_token(KIND_END);
                end else begin
                    add_token(op_kind(op_byte, 1'b0));
                    add_end_here();
                end
            end
            default: ;
        endcase
        lex_reset();
    endtask

    task automatic predict_beat(logic [7:0] c, logic eot);
        beat_recs.delete();
        if (eot)
            lex_end();
        else
            lex_byte(c);
        if (beat_recs.size() > 0)
            beat_recs[beat_recs.size() - 1].last = 1'b1;
        foreach (beat_recs[i])
            want_recs.insert(want_recs.size(), beat_recs[i]);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (o_fail_count < 100)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    initial begin
        lex_reset();
    end

    // input beat is predicted before the output beat of the same edge is checked
    always @(posedge i_clk) begin : watch
        t_rec want;
        if (!i_rst_n) begin
            lex_reset();
            want_recs.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_beat(i_ch, i_end_of_text);
            if (i_out_valid && i_out_ready) begin
                if (want_recs.size() == 0) begin
                    report_mismatch("record with nothing expected", 64'(i_record_type),
                                    64'(0));
                end else begin
                    want = want_recs.pop_front();
                    check_field("record_type", 64'(i_record_type), 64'(want.rtype));
                    check_field("token_kind", 64'(i_token_kind), 64'(want.kind));
                    check_field("token_line", 64'(i_token_line), 64'(want.line));
                    check_field("token_column", 64'(i_token_column), 64'(want.col));
                    check_field("number_value", i_number_value, want.value);
                    check_field("text_byte", 64'(i_text_byte), 64'(want.tbyte));
                    check_field("error_code", 64'(i_error_code), 64'(want.err));
                    check_field("last", 64'(i_last), 64'(want.last));
                end
            end
        end
        o_pending <= want_recs.size();
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the script tokenizer: source text stimulus, random stalls and verdict.
module tb_top
    import stok_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [7:0]                     i_ch;
    logic                           i_end_of_text;
    logic                           o_valid;
    logic                           i_ready;
    logic [1:0]                     o_record_type;
    logic [4:0]                     o_token_kind;
    logic [LINE_WIDTH-1:0]          o_token_line;
    logic [COLUMN_WIDTH-1:0]        o_token_column;
    logic signed [VALUE_WIDTH-1:0]  o_number_value;
    logic [7:0]                     o_text_byte;
    logic                           o_error_code;
    logic                           o_last;

    int fail_count;
    int pending;
    int beats_sent;

    logic [7:0] src_text[$];

    script_tokenizer dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_ch, .i_end_of_text,
        .o_valid, .i_ready, .o_record_type, .o_token_kind, .o_token_line,
        .o_token_column, .o_number_value, .o_text_byte, .o_error_code, .o_last
    );

    tok_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_ch           (i_ch),
        .i_end_of_text  (i_end_of_text),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_record_type  (o_record_type),
        .i_token_kind   (o_token_kind),
        .i_token_line   (o_token_line),
        .i_token_column (o_token_column),
        .i_number_value (o_number_value),
        .i_text_byte    (o_text_byte),
        .i_error_code   (o_error_code),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_byte(logic [7:0] b);
        src_text.insert(src_text.size(), b);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // one beat; valid stays high from the previous beat when there is no gap
    task automatic send_beat(logic [7:0] c, logic eot);
        int  gap;
        logic took;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ch          <= c;
        i_end_of_text <= eot;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        beats_sent++;
    endtask

    task automatic send_text();
        foreach (src_text[i])
            send_beat(src_text[i], 1'b0);
        send_beat(rand_byte(), 1'b1);
        src_text.delete();
    endtask

    task automatic run_text(string s);
        add_str(s);
        send_text();
    endtask

    // hold the sender off until every predicted record has been taken
    task automatic settle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        @(posedge i_clk);
    endtask

    task automatic add_piece();
        case ($urandom_range(0, 5))
            0: begin
                add_str(pick_char("abcxyzABCXYZ_"));
                repeat ($urandom_range(0, 6))
                    add_str(pick_char("abcmnxyzABMNXZ_0123456789"));
            end
            1: begin
                if ($urandom_range(0, 9) < 3)
                    add_str("-");
                repeat ($urandom_range(0, 4) == 0 ? $urandom_range(15, 24) : $urandom_range(1, 4))
                    add_str(pick_char("0123456789"));
                if ($urandom_range(0, 3) == 0) begin
                    add_str(".");
                    repeat ($urandom_range(0, 3))
                        add_str(pick_char("0123456789."));
                end
            end
            2: begin
                add_str("\"");
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 99) < 15) begin
                        add_str("\\");
                        add_byte($urandom_range(0, 1) ? rand_byte() : pick_char("ntr\"\\q"));
                    end else begin
                        add_byte(rand_byte());
                        // a bare quote or backslash would end or escape early
                        if (src_text[$] == CH_QUOTE || src_text[$] == CH_BSLASH) begin
                            src_text.insert(src_text.size() - 1, CH_BSLASH);
                        end
                    end
                end
                add_str("\"");
            end
            3, 4: begin
                case ($urandom_range(0, 19))
                    0:  add_str(":");
                    1:  add_str(",");
                    2:  add_str(";");
                    3:  add_str(".");
                    4:  add_str("{");
                    5:  add_str("}");
                    6:  add_str("(");
                    7:  add_str(")");
                    8:  add_str("[");
                    9:  add_str("]");
                    10: add_str("+=");
                    11: add_str("->");
                    12: add_str("-=");
                    13: add_str("==");
                    14: add_str("=");
                    15: add_str("!=");
                    16: add_str(">=");
                    17: add_str(">");
                    18: add_str("<=");
                    default: add_str("<");
                endcase
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    add_str("//");
                    repeat ($urandom_range(0, 5))
                        add_byte(8'($urandom_range(8'h20, 8'h7E)));
                    add_str("\n");
                end else begin
                    add_str("/*");
                    repeat ($urandom_range(0, 6))
                        add_str(pick_char("ab *\n"));
                    add_str("*/");
                end
            end
        endcase
        case ($urandom_range(0, 5))
            0: ;
            1: add_str(" ");
            2: add_str("\t");
            3: add_str("\r");
            4: add_str("\n");
            default: add_str("  ");
        endcase
    endtask

    task automatic add_broken_tail();
        case ($urandom_range(0, 7))
            0: add_str("+");
            1: add_str("-");
            2: add_str("!");
            3: add_byte($urandom_range(0, 1) ? pick_char("#$%&'?@^`|~")
                                             : 8'($urandom_range(8'h80, 8'hFF)));
            4: add_str("/");
            5: add_str("\"ab");
            6: add_str("/* x");
            default: add_str("\"a\\");
        endcase
        // random bytes may follow the broken tail
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 4))
                add_byte(rand_byte());
    endtask

    task automatic build_random_text();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 12))
                add_byte(rand_byte());
        end else begin
            repeat ($urandom_range(1, 8))
                add_piece();
            if ($urandom_range(0, 99) < 20)
                add_broken_tail();
        end
    endtask

    task automatic run_directed();
        send_text();
        run_text("_azAZ09 0 9 -1");
        run_text("18446744073709551617 -9223372036854775808 3.14.15 -2.");
        run_text("\"q\\\"\\\\\\n\\t\\r\\z\nw\"x");
        run_text("+x yy");
        run_text("- 3");
        run_text("!a");
        run_text("#");
        run_text("/x");
        run_text("\"ab");
        run_text("\"a\\");
        run_text("/* a\n*");
        run_text("// c");
        run_text("<");
        run_text("+");
        run_text("-");
        run_text("/");
        run_text("a=");
        add_byte(8'h00);
        send_text();
        add_byte(8'hFF);
        send_text();
        add_str("ab\ncd");
        send_text();
    endtask

    initial begin : sink
        int n;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : stim
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_ch          <= 8'h00;
        i_end_of_text <= 1'b0;
        beats_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        settle();

        while (beats_sent < 350) begin
            build_random_text();
            send_text();
            if ($urandom_range(0, 9) == 0)
                settle();
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (pending != 0)
            $display("%0d expected records never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/stok_pkg.sv
rtl/stok_lexer.sv
rtl/script_tokenizer.sv
test/tok_checker.sv
test/tb_top.sv
